// ----- design/agtr_pkg.sv -----
// Shared widths, register codes and grid helper functions for the tile layout block.
package agtr_pkg;

    localparam int COUNT_W   = 7;
    localparam int DIM_W     = 13;
    localparam int INDEX_W   = 6;
    localparam int GRID_W    = 4;
    localparam int POS_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int RECIP_W   = 14;
    localparam int RECIP_SHIFT = 13;

    localparam int MAX_TILES  = 64;
    localparam int MAX_CANVAS = 8191;
    localparam int MAX_GRID   = 8;

    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [DIM_W-1:0]     t_dim;
    typedef logic [INDEX_W-1:0]   t_index;
    typedef logic [GRID_W-1:0]    t_grid;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_TILE_COUNT    = 2'd0;
    localparam t_cfg_idx CFG_CANVAS_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_CANVAS_HEIGHT = 2'd2;

    // floor(2^RECIP_SHIFT / d) for d = 1..8; unused divisors read zero
    localparam logic [RECIP_W-1:0] RECIP_TABLE [0:15] = '{
        14'd0,    14'd8192, 14'd4096, 14'd2730, 14'd2048, 14'd1638, 14'd1365, 14'd1170,
        14'd1024, 14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0
    };

    // Smallest c >= 1 with c*c >= n; counts above the grid limit saturate.
    function automatic t_grid grid_cols(input t_count n);
        t_grid c;
        c = t_grid'(MAX_GRID);
        for (int k = MAX_GRID - 1; k >= 1; k--) begin
            if (COUNT_W'(k * k) >= n) begin
                c = t_grid'(k);
            end
        end
        return c;
    endfunction

    // Smallest r >= 1 with r*cols >= n, i.e. ceil(n / cols) for a nonzero count.
    function automatic t_grid grid_rows(input t_count n, input t_grid cols);
        t_grid r;
        r = t_grid'(MAX_GRID);
        for (int k = MAX_GRID - 1; k >= 1; k--) begin
            if (COUNT_W'(k * int'(cols)) >= n) begin
                r = t_grid'(k);
            end
        end
        return r;
    endfunction

    // Row of a tile: the largest k below the grid limit with k*cols <= idx.
    function automatic t_pos tile_row(input t_index idx, input t_grid cols);
        t_pos r;
        r = '0;
        for (int k = 1; k < MAX_GRID; k++) begin
            if (COUNT_W'(k * int'(cols)) <= {1'b0, idx}) begin
                r = t_pos'(k);
            end
        end
        return r;
    endfunction

    function automatic t_pos tile_col(input t_index idx, input t_grid cols, input t_pos row);
        return t_pos'(int'(idx) - int'(row) * int'(cols));
    endfunction

endpackage

// ----- design/auto_grid_tile_rectangles.sv -----
// Top level: near-square grid tile placement pipeline with its configuration registers.
//
// Each accepted tile index yields exactly one result: the item taken at the edge where start is
// high is presented with o_strobe high during the cycle after the fifth register stage, and is
// accepted at the edge that ends that cycle. The pipeline takes one index every clock, so busy
// stays low; the stages are grid sizing, row and column split with the reciprocal multiply, the
// quotient correction, the position multiply, and the output register. The receiver cannot
// stall the block, so results are never held.
// Configuration writes land at once and are meant to be made while no item is in flight.
module auto_grid_tile_rectangles (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  agtr_pkg::t_index      i_tile_index,
    input  logic                  i_cfg_we,
    input  agtr_pkg::t_cfg_idx    i_cfg_idx,
    input  agtr_pkg::t_dim        i_cfg_data,
    output logic                  o_strobe,
    output logic                  o_valid_res,
    output agtr_pkg::t_dim        o_left,
    output agtr_pkg::t_dim        o_top,
    output agtr_pkg::t_dim        o_span_x,
    output agtr_pkg::t_dim        o_span_y
);

    agtr_pkg::t_count r_tile_count;
    agtr_pkg::t_dim   r_canvas_width;
    agtr_pkg::t_dim   r_canvas_height;

    logic             n_accept;
    logic             n_ok;

    // stage 1
    logic             r_s1_valid;
    logic             r_s1_ok;
    agtr_pkg::t_index r_s1_idx;
    agtr_pkg::t_grid  r_s1_cols;
    agtr_pkg::t_grid  r_s1_rows;

    // stage 2
    agtr_pkg::t_pos   n_s2_row;
    agtr_pkg::t_pos   n_s2_col;
    logic             r_s2_valid;
    logic             r_s2_ok;
    agtr_pkg::t_pos   r_s2_row;
    agtr_pkg::t_pos   r_s2_col;
    logic             r_s2_last_col;
    logic             r_s2_last_row;

    // stage 3
    agtr_pkg::t_dim   n_cell_w;
    agtr_pkg::t_dim   n_cell_h;
    logic             r_s3_valid;
    logic             r_s3_ok;
    agtr_pkg::t_pos   r_s3_row;
    agtr_pkg::t_pos   r_s3_col;
    logic             r_s3_last_col;
    logic             r_s3_last_row;

    // stage 4
    logic             r_s4_valid;
    logic             r_s4_ok;
    agtr_pkg::t_dim   r_s4_left;
    agtr_pkg::t_dim   r_s4_top;
    agtr_pkg::t_dim   r_s4_cell_w;
    agtr_pkg::t_dim   r_s4_cell_h;
    logic             r_s4_last_col;
    logic             r_s4_last_row;

    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_count    <= '0;
            r_canvas_width  <= '0;
            r_canvas_height <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                agtr_pkg::CFG_TILE_COUNT:    r_tile_count    <= i_cfg_data[agtr_pkg::COUNT_W-1:0];
                agtr_pkg::CFG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg_data;
                agtr_pkg::CFG_CANVAS_HEIGHT: r_canvas_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_ok = (r_tile_count != '0) && (r_canvas_width != '0) && (r_canvas_height != '0)
               && ({1'b0, i_tile_index} < r_tile_count)
               && (int'(r_tile_count) <= agtr_pkg::MAX_TILES)
               && (int'(r_canvas_width) <= agtr_pkg::MAX_CANVAS)
               && (int'(r_canvas_height) <= agtr_pkg::MAX_CANVAS);

    // Stage 1: size the grid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ok   <= n_ok;
        r_s1_idx  <= i_tile_index;
        r_s1_cols <= agtr_pkg::grid_cols(r_tile_count);
        r_s1_rows <= agtr_pkg::grid_rows(r_tile_count, agtr_pkg::grid_cols(r_tile_count));
    end

    // Stage 2: split the index into row and column; dividers start here.
    assign n_s2_row = agtr_pkg::tile_row(r_s1_idx, r_s1_cols);
    assign n_s2_col = agtr_pkg::tile_col(r_s1_idx, r_s1_cols, n_s2_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ok       <= r_s1_ok;
        r_s2_row      <= n_s2_row;
        r_s2_col      <= n_s2_col;
        r_s2_last_col <= ({1'b0, n_s2_col} + agtr_pkg::t_grid'(1)) == r_s1_cols;
        r_s2_last_row <= ({1'b0, n_s2_row} + agtr_pkg::t_grid'(1)) == r_s1_rows;
    end

    agtr_div u_div_w (
        .i_clk      (i_clk),
        .i_dividend (r_canvas_width),
        .i_divisor  (r_s1_cols),
        .o_quot     (n_cell_w)
    );

    agtr_div u_div_h (
        .i_clk      (i_clk),
        .i_dividend (r_canvas_height),
        .i_divisor  (r_s1_rows),
        .o_quot     (n_cell_h)
    );

    // Stage 3: carry the position along while the dividers finish.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_ok       <= r_s2_ok;
        r_s3_row      <= r_s2_row;
        r_s3_col      <= r_s2_col;
        r_s3_last_col <= r_s2_last_col;
        r_s3_last_row <= r_s2_last_row;
    end

    // Stage 4: place the tile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_ok       <= r_s3_ok;
        r_s4_left     <= agtr_pkg::DIM_W'(agtr_pkg::t_dim'(r_s3_col) * n_cell_w);
        r_s4_top      <= agtr_pkg::DIM_W'(agtr_pkg::t_dim'(r_s3_row) * n_cell_h);
        r_s4_cell_w   <= n_cell_w;
        r_s4_cell_h   <= n_cell_h;
        r_s4_last_col <= r_s3_last_col;
        r_s4_last_row <= r_s3_last_row;
    end

    // Stage 5: stretch the last column and row, zero an invalid item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe    <= 1'b0;
            o_valid_res <= 1'b0;
        end else begin
            o_strobe    <= r_s4_valid;
            o_valid_res <= r_s4_valid && r_s4_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s4_ok) begin
            o_left   <= r_s4_left;
            o_top    <= r_s4_top;
            o_span_x <= r_s4_last_col ? (r_canvas_width - r_s4_left) : r_s4_cell_w;
            o_span_y <= r_s4_last_row ? (r_canvas_height - r_s4_top) : r_s4_cell_h;
        end else begin
            o_left   <= '0;
            o_top    <= '0;
            o_span_x <= '0;
            o_span_y <= '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |-> ##5 o_strobe)
        else $error("accepted item produced no result after five cycles");

    a_strobe_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_valid_res)
        else $error("valid result flagged without a strobe");

    a_invalid_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |->
            (o_left == '0) && (o_top == '0) && (o_span_x == '0) && (o_span_y == '0))
        else $error("invalid result carries nonzero rectangle");
`endif

endmodule

// ----- design/agtr_div.sv -----
// Two-stage divider of a canvas dimension by a small grid count using a reciprocal table.
module agtr_div (
    input  logic              i_clk,
    input  agtr_pkg::t_dim    i_dividend,
    input  agtr_pkg::t_grid   i_divisor,
    output agtr_pkg::t_dim    o_quot
);

    localparam int PROD_W = agtr_pkg::DIM_W + agtr_pkg::RECIP_W;
    localparam int QD_W   = agtr_pkg::DIM_W + agtr_pkg::GRID_W;

    logic [PROD_W-1:0] n_prod;
    agtr_pkg::t_dim    r_est;
    agtr_pkg::t_dim    r_dividend;
    agtr_pkg::t_grid   r_divisor;
    logic [QD_W-1:0]   n_qd;
    logic [QD_W-1:0]   n_rem;
    agtr_pkg::t_dim    r_quot;

    // Estimate is low by at most one.
    assign n_prod = PROD_W'(i_dividend) * PROD_W'(agtr_pkg::RECIP_TABLE[i_divisor]);

    always_ff @(posedge i_clk) begin
        r_est      <= n_prod[agtr_pkg::RECIP_SHIFT +: agtr_pkg::DIM_W];
        r_dividend <= i_dividend;
        r_divisor  <= i_divisor;
    end

    assign n_qd  = QD_W'(r_est) * QD_W'(r_divisor);
    assign n_rem = QD_W'(r_dividend) - n_qd;

    // Bump the estimate when the remainder still holds one more divisor.
    always_ff @(posedge i_clk) begin
        r_quot <= r_est + agtr_pkg::DIM_W'(n_rem >= QD_W'(r_divisor));
    end

    assign o_quot = r_quot;

endmodule

// ----- tb/auto_grid_tile_rectangles_test.sv -----
// Testbench for the grid tile placement block: directed and random lookups against a predictor.
module auto_grid_tile_rectangles_test;
    timeunit 1ns;
    timeprecision 1ps;

    import agtr_pkg::*;

    localparam t_cfg_idx CFG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 20;

    typedef enum bit {REQ_TILE, REQ_CFG} t_req_kind;

    typedef struct {
        t_req_kind kind;
        t_cfg_idx  cfg_sel;
        t_dim      cfg_data;
        t_index    tile;
    } t_layout_req;

    typedef struct packed {
        logic valid;
        t_dim left;
        t_dim top;
        t_dim span_x;
        t_dim span_y;
    } t_tile_rect;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    t_index   i_tile_index = '0;
    logic     i_cfg_we = 1'b0;
    t_cfg_idx i_cfg_idx = '0;
    t_dim     i_cfg_data = '0;
    logic     o_strobe;
    logic     o_valid_res;
    t_dim     o_left;
    t_dim     o_top;
    t_dim     o_span_x;
    t_dim     o_span_y;

    t_layout_req pending_items[$];
    t_tile_rect  rect_expected[$];
    int          error_count = 0;
    bit          item_taken = 1'b0;
    int          gap_left = 0;
    bit          burst_mode = 1'b0;

    // Register copies seen by the predictor
    t_count layout_count = '0;
    t_dim   layout_width = '0;
    t_dim   layout_height = '0;

    // Copy of the tile count register used while building the stimulus
    int gen_count = 0;

    auto_grid_tile_rectangles dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_tile_index (i_tile_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_valid_res  (o_valid_res),
        .o_left       (o_left),
        .o_top        (o_top),
        .o_span_x     (o_span_x),
        .o_span_y     (o_span_y)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_tile_rect place_tile(input t_index idx);
        t_tile_rect rect;
        int n, w, h, cols, rows, cell_w, cell_h, col, row, x, y;
        rect = '0;
        n = int'(layout_count);
        w = int'(layout_width);
        h = int'(layout_height);
        if (n == 0 || w == 0 || h == 0 || int'(idx) >= n || n > MAX_TILES ||
            w > MAX_CANVAS || h > MAX_CANVAS) begin
            return rect;
        end
        cols = 1;
        while (cols * cols < n) cols++;
        rows = (n + cols - 1) / cols;
        cell_w = w / cols;
        cell_h = h / rows;
        col = int'(idx) % cols;
        row = int'(idx) / cols;
        x = col * cell_w;
        y = row * cell_h;
        rect.valid  = 1'b1;
        rect.left   = t_dim'(x);
        rect.top    = t_dim'(y);
        // stretch the last column and the last row to the canvas edge
        rect.span_x = t_dim'((col + 1 == cols) ? (w - x) : cell_w);
        rect.span_y = t_dim'((row + 1 == rows) ? (h - y) : cell_h);
        return rect;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        error_count++;
    endtask

    task automatic push_cfg(input t_cfg_idx sel, input t_dim data);
        t_layout_req req;
        req.kind = REQ_CFG;
        req.cfg_sel = sel;
        req.cfg_data = data;
        req.tile = '0;
        pending_items.insert(pending_items.size(), req);
        if (sel == CFG_TILE_COUNT) gen_count = int'(data[COUNT_W-1:0]);
    endtask

    task automatic push_tile(input t_index idx);
        t_layout_req req;
        req.kind = REQ_TILE;
        req.cfg_sel = CFG_TILE_COUNT;
        req.cfg_data = '0;
        req.tile = idx;
        pending_items.insert(pending_items.size(), req);
    endtask

    function automatic t_dim pick_dim();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0: return '0;
            1: return t_dim'(MAX_CANVAS);
            2: return t_dim'(1);
            3, 4, 5: return t_dim'($urandom_range(1, 16));
            default: return t_dim'($urandom_range(1, MAX_CANVAS));
        endcase
    endfunction

    function automatic t_dim pick_count_data();
        int pick;
        t_count cnt;
        t_dim data;
        pick = $urandom_range(0, 19);
        case (pick)
            0: cnt = '0;
            1: cnt = t_count'(MAX_TILES);
            2: cnt = t_count'($urandom_range(MAX_TILES + 1, 127));
            3, 4, 5, 6: cnt = t_count'($urandom_range(1, 9));
            default: cnt = t_count'($urandom_range(1, MAX_TILES));
        endcase
        data = t_dim'(cnt);
        // upper data bits are dropped by the count register
        if ($urandom_range(0, 1) == 1) data[DIM_W-1:COUNT_W] = (DIM_W - COUNT_W)'($urandom);
        return data;
    endfunction

    function automatic int pick_gap();
        int pick;
        if ($urandom_range(0, 79) == 0) burst_mode = ~burst_mode;
        if (burst_mode) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Driver: change inputs on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else if (start && !item_taken) begin
            // hold the item until it is taken
        end else if (gap_left > 0) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
            gap_left--;
        end else if (pending_items.size() == 0) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else if (pending_items[0].kind == REQ_CFG) begin
            start <= 1'b0;
            // write registers only once the pipeline has drained
            if (!start && rect_expected.size() == 0) begin
                i_cfg_we <= 1'b1;
                i_cfg_idx <= pending_items[0].cfg_sel;
                i_cfg_data <= pending_items[0].cfg_data;
                void'(pending_items.pop_front());
            end else begin
                i_cfg_we <= 1'b0;
            end
        end else begin
            i_cfg_we <= 1'b0;
            start <= 1'b1;
            i_tile_index <= pending_items[0].tile;
            void'(pending_items.pop_front());
            gap_left = pick_gap();
        end
    end

    // Monitor: sample on the rising edge
    always @(posedge i_clk) begin
        t_tile_rect want;
        if (!i_rst_n) begin
            item_taken = 1'b0;
            layout_count = '0;
            layout_width = '0;
            layout_height = '0;
        end else begin
            if (o_strobe === 1'b1) begin
                if (rect_expected.size() == 0) begin
                    report_mismatch("unexpected result count", 0, 1);
                end else begin
                    want = rect_expected.pop_front();
                    if (o_valid_res !== want.valid)
                        report_mismatch("valid_res", int'(want.valid), int'(o_valid_res));
                    if (o_left !== want.left)
                        report_mismatch("left", int'(want.left), int'(o_left));
                    if (o_top !== want.top)
                        report_mismatch("top", int'(want.top), int'(o_top));
                    if (o_span_x !== want.span_x)
                        report_mismatch("span_x", int'(want.span_x), int'(o_span_x));
                    if (o_span_y !== want.span_y)
                        report_mismatch("span_y", int'(want.span_y), int'(o_span_y));
                end
            end
            item_taken = start && (busy === 1'b0);
            if (item_taken)
                rect_expected.insert(rect_expected.size(), place_tile(i_tile_index));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TILE_COUNT:    layout_count = i_cfg_data[COUNT_W-1:0];
                    CFG_CANVAS_WIDTH:  layout_width = i_cfg_data;
                    CFG_CANVAS_HEIGHT: layout_height = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        int total;
        int n_items;
        t_index idx;

        // Registers at reset: nothing is placed
        push_tile(6'd0);
        push_tile(6'd63);
        // Single tile on the largest canvas, then an index beyond the count
        push_cfg(CFG_TILE_COUNT, 13'd1);
        push_cfg(CFG_CANVAS_WIDTH, 13'd8191);
        push_cfg(CFG_CANVAS_HEIGHT, 13'd8191);
        push_tile(6'd0);
        push_tile(6'd1);
        // Full 8x8 grid
        push_cfg(CFG_TILE_COUNT, 13'd64);
        push_tile(6'd0);
        push_tile(6'd7);
        push_tile(6'd8);
        push_tile(6'd56);
        push_tile(6'd63);
        // Count above the tile limit, with dropped upper data bits
        push_cfg(CFG_TILE_COUNT, 13'h1FC1);
        push_tile(6'd0);
        push_tile(6'd63);
        // Empty canvas, then a canvas narrower than the grid
        push_cfg(CFG_TILE_COUNT, 13'h1F85);
        push_cfg(CFG_CANVAS_WIDTH, 13'd0);
        push_tile(6'd0);
        push_cfg(CFG_CANVAS_WIDTH, 13'd1);
        push_cfg(CFG_CANVAS_HEIGHT, 13'd1);
        push_tile(6'd0);
        push_tile(6'd4);
        // Write to an unused register index must leave everything alone
        push_cfg(CFG_UNUSED, 13'h1FFF);
        push_tile(6'd2);
        // Zero height, then a ragged last row
        push_cfg(CFG_TILE_COUNT, 13'd7);
        push_cfg(CFG_CANVAS_WIDTH, 13'd1000);
        push_cfg(CFG_CANVAS_HEIGHT, 13'd0);
        push_tile(6'd3);
        push_cfg(CFG_CANVAS_HEIGHT, 13'd999);
        push_tile(6'd0);
        push_tile(6'd2);
        push_tile(6'd3);
        push_tile(6'd6);

        // Random phases: new settings, then a burst of lookups
        total = 0;
        while (total < RANDOM_ITEMS) begin
            if (total == 0 || $urandom_range(0, 4) != 0) push_cfg(CFG_TILE_COUNT, pick_count_data());
            if (total == 0 || $urandom_range(0, 4) != 0) push_cfg(CFG_CANVAS_WIDTH, pick_dim());
            if (total == 0 || $urandom_range(0, 4) != 0) push_cfg(CFG_CANVAS_HEIGHT, pick_dim());
            if ($urandom_range(0, 7) == 0) push_cfg(CFG_UNUSED, t_dim'($urandom));
            n_items = $urandom_range(20, 90);
            for (int k = 0; k < n_items; k++) begin
                if (gen_count >= 1 && gen_count <= MAX_TILES && $urandom_range(0, 7) != 0)
                    idx = t_index'($urandom_range(0, gen_count - 1));
                else
                    idx = t_index'($urandom_range(0, 63));
                push_tile(idx);
            end
            total += n_items;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_items.size() != 0 || start || rect_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[%0t] timeout", $realtime);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- auto_grid_tile_rectangles.f -----
design/agtr_pkg.sv
design/agtr_div.sv
design/auto_grid_tile_rectangles.sv
tb/auto_grid_tile_rectangles_test.sv
